[rtl/core/rrl_pkg.sv]
// Package for the round-robin ring list.
// Holds sizes, request and status codes, and the cell command/status structs.
// No dependencies.
package rrl_pkg;

  localparam int unsigned CAPACITY = 16;
  localparam int unsigned ID_W     = 16;
  localparam int unsigned IDX_W    = $clog2(CAPACITY);
  localparam int unsigned CNT_W    = 5;

  typedef enum logic [1:0] {
    FUNC_ADD    = 2'd0,
    FUNC_REMOVE = 2'd1,
    FUNC_NEXT   = 2'd2,
    FUNC_NONE   = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_e;

  // Broadcast to every cell in the chain.
  typedef struct packed {
    logic             add_en;
    logic             rm_en;
    logic [ID_W-1:0]  id;
    logic [CNT_W-1:0] count;
    logic [IDX_W-1:0] pos;
  } cell_cmd_t;

  // Reported by each cell.
  typedef struct packed {
    logic hit;         // a match at this cell or any cell to its left
    logic first;       // this cell holds the first match
    logic before_pos;  // first match lies before the current position
  } cell_stat_t;

endpackage

[rtl/core/rrl_cell.sv]
// One entry cell of the round-robin ring list chain.
// Holds one identifier, compares it on remove and shifts in its right neighbor.
// Depends on rrl_pkg.
module rrl_cell
  import rrl_pkg::*;
(
  input  logic             clk_i,
  input  logic [IDX_W-1:0] idx_i,
  input  cell_cmd_t        cmd_i,
  input  logic             prev_hit_i,
  input  logic [ID_W-1:0]  next_entry_i,
  output logic [ID_W-1:0]  entry_o,
  output cell_stat_t       stat_o
);

  logic [ID_W-1:0] entry_q, entry_d;
  logic            valid;
  logic            match;

  assign valid = ({1'b0, idx_i} < cmd_i.count);
  assign match = valid && (entry_q == cmd_i.id);

  assign stat_o.hit        = prev_hit_i || match;
  assign stat_o.first      = match && !prev_hit_i;
  assign stat_o.before_pos = stat_o.first && (idx_i < cmd_i.pos);

  always_comb begin
    entry_d = entry_q;
    if (cmd_i.add_en && ({1'b0, idx_i} == cmd_i.count)) begin
      entry_d = cmd_i.id;
    end else if (cmd_i.rm_en && stat_o.hit) begin
      // close the gap: take the neighbor's entry
      entry_d = next_entry_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

[rtl/core/round_robin_ring_list_top.sv]
// Top level of the round-robin ring list.
// Instantiates a chain of rrl_cell entries and the count/position control.
// Depends on rrl_pkg and rrl_cell.
//
// Usage:
//   Drive func_i and elem_id_i with start high; the request is taken at a
//   rising edge where start is high and busy is low. busy stays low, so a
//   request can be taken in every cycle: one request per cycle sustained.
//   The result (served_id_o, status_o, entry_count_o) appears for exactly one
//   cycle, marked by done_o, in the cycle after the request is taken.
//   Every request kind is done in one registered update: add writes the tail cell,
//   remove compares in all cells at once and every cell at or right of the
//   first match takes its neighbor's entry, next selects the cell at the
//   current position. The match search is a one-bit chain through the cells.
//   Requests: add appends (status full at capacity), remove deletes the first
//   match (status not found otherwise), next serves and advances with wrap
//   (status empty on an empty list). Function code 3 changes nothing.
//   Reset clears the entry count and the position; the entries themselves
//   are left as they are. The receiver cannot stall: done_o is a pulse.
module round_robin_ring_list_top
  import rrl_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  logic [1:0]       func_i,
  input  logic [ID_W-1:0]  elem_id_i,
  output logic             done_o,
  output logic [ID_W-1:0]  served_id_o,
  output logic [1:0]       status_o,
  output logic [CNT_W-1:0] entry_count_o
);

  logic [CNT_W-1:0] count_q, count_d;
  logic [IDX_W-1:0] pos_q, pos_d;
  logic             done_q;
  logic [ID_W-1:0]  served_q, served_d;
  status_e          status_q, status_d;

  logic             accept;
  func_e            func;
  cell_cmd_t        cmd;
  logic [ID_W-1:0]  entries [CAPACITY];
  cell_stat_t       stats [CAPACITY];
  logic             found;
  logic             dec;
  logic             full;
  logic             empty;
  logic [IDX_W-1:0] pos_m;
  logic [CNT_W-1:0] cnt_m;
  logic [CNT_W-1:0] pos_inc;

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign func   = func_e'(func_i);
  assign full   = (count_q == CNT_W'(CAPACITY));
  assign empty  = (count_q == '0);

  assign cmd.add_en = accept && (func == FUNC_ADD) && !full;
  assign cmd.rm_en  = accept && (func == FUNC_REMOVE);
  assign cmd.id     = elem_id_i;
  assign cmd.count  = count_q;
  assign cmd.pos    = pos_q;

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic            prev_hit;
    logic [ID_W-1:0] next_entry;
    if (g == 0) begin : g_first
      assign prev_hit = 1'b0;
    end else begin : g_rest
      assign prev_hit = stats[g-1].hit;
    end
    if (g == CAPACITY - 1) begin : g_last
      assign next_entry = entries[g];
    end else begin : g_mid
      assign next_entry = entries[g+1];
    end
    rrl_cell u_cell (
      .clk_i        (clk_i),
      .idx_i        (IDX_W'(g)),
      .cmd_i        (cmd),
      .prev_hit_i   (prev_hit),
      .next_entry_i (next_entry),
      .entry_o      (entries[g]),
      .stat_o       (stats[g])
    );
  end

  assign found = stats[CAPACITY-1].hit;

  always_comb begin
    dec = 1'b0;
    for (int i = 0; i < CAPACITY; i++) begin
      dec = dec | stats[i].before_pos;
    end
  end

  assign pos_m   = pos_q - IDX_W'(dec);
  assign cnt_m   = count_q - CNT_W'(1);
  assign pos_inc = {1'b0, pos_q} + CNT_W'(1);

  always_comb begin
    count_d  = count_q;
    pos_d    = pos_q;
    served_d = '0;
    status_d = ST_OK;
    if (accept) begin
      unique case (func)
        FUNC_ADD: begin
          if (full) begin
            status_d = ST_FULL;
          end else begin
            count_d = count_q + CNT_W'(1);
          end
        end
        FUNC_REMOVE: begin
          if (!found) begin
            status_d = ST_NOT_FOUND;
          end else begin
            count_d = cnt_m;
            // step back past the removed entry, wrap if off the end
            pos_d   = ({1'b0, pos_m} >= cnt_m) ? '0 : pos_m;
          end
        end
        FUNC_NEXT: begin
          if (empty) begin
            status_d = ST_EMPTY;
          end else begin
            served_d = entries[pos_q];
            pos_d    = (pos_inc >= count_q) ? '0 : pos_inc[IDX_W-1:0];
          end
        end
        FUNC_NONE: begin
          status_d = ST_OK;
        end
        default: begin
          status_d = ST_OK;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      pos_q    <= '0;
      done_q   <= 1'b0;
      status_q <= ST_OK;
    end else begin
      count_q  <= count_d;
      pos_q    <= pos_d;
      done_q   <= accept;
      status_q <= status_d;
    end
  end

  always_ff @(posedge clk_i) begin
    served_q <= served_d;
  end

  assign done_o        = done_q;
  assign served_id_o   = served_q;
  assign status_o      = status_q;
  assign entry_count_o = count_q;

endmodule
